[src/gsdq_pkg.sv]
// Shared types, constants and helper functions for the gamepad stick direction quantizer.
`timescale 1ns / 1ps

package gsdq_pkg;

    // Field widths
    localparam int AxisW    = 16;
    localparam int MarginW  = 15;
    localparam int DirW     = 4;
    localparam int PowerW   = 8;
    localparam int PctW     = 7;
    localparam int CfgIdxW  = 2;
    localparam int InDataW  = 96;
    localparam int OutDataW = 48;

    // Square root datapath: radicand holds 10000 * (x*x + y*y) < 2^45
    localparam int SqW       = 31;
    localparam int RadW      = 46;
    localparam int RootW     = RadW / 2;
    localparam int RemW      = RootW + 2;
    localparam int RootSteps = RadW / 2;
    localparam int StepW     = 5;
    localparam int PowerShift = 15;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgDeadZone   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgTurnHold   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgPowerEn    = 2'd2;

    // Reset values
    localparam logic [MarginW-1:0] DeadZoneReset = 15'd2000;
    localparam logic [PowerW-1:0]  PowerUnknown  = 8'hFF;
    localparam logic [PctW-1:0]    PowerMax      = 7'd100;

    // Direction codes
    typedef enum logic [DirW-1:0] {
        DIR_NONE = 4'd0,
        DIR_N    = 4'd1,
        DIR_NE   = 4'd2,
        DIR_E    = 4'd3,
        DIR_SE   = 4'd4,
        DIR_S    = 4'd5,
        DIR_SW   = 4'd6,
        DIR_W    = 4'd7,
        DIR_NW   = 4'd8
    } dir_t;

    // Status from one stick lane to the merge stage
    typedef struct packed {
        logic            done;
        dir_t            direction;
        logic [PctW-1:0] power;
    } lane_result_t;

    // Trigger percentage: 25*|t|/16384 truncated toward zero, signed, plus 50
    function automatic logic [PctW-1:0] trigger_power(input logic [AxisW-1:0] t);
        logic [AxisW:0]   ext;
        logic [AxisW:0]   mag;
        logic [21:0]      prod;
        logic [PctW-1:0]  q;
        ext  = {t[AxisW-1], t};
        mag  = t[AxisW-1] ? ((AxisW+1)'(0) - ext) : ext;
        prod = 22'(mag) * 22'd25;
        q    = PctW'(prod[21:14]);
        return t[AxisW-1] ? (PctW'(50) - q) : (PctW'(50) + q);
    endfunction

    // Trigger held: t strictly above 2*m - 32768
    function automatic logic trigger_held(input logic [AxisW-1:0] t,
                                          input logic [MarginW-1:0] m);
        logic signed [AxisW+1:0] thr;
        logic signed [AxisW+1:0] tv;
        thr = $signed({2'b00, m, 1'b0}) - $signed(18'd32768);
        tv  = $signed({{2{t[AxisW-1]}}, t});
        return tv > thr;
    endfunction

endpackage

[src/gsdq_stick_lane.sv]
// One stick lane: eight-way direction with turn-hold flag, and iterative magnitude.
`timescale 1ns / 1ps

module gsdq_stick_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [gsdq_pkg::AxisW-1:0]        x,
    input  logic [gsdq_pkg::AxisW-1:0]        y,
    input  logic [gsdq_pkg::MarginW-1:0]      dead_zone,
    input  logic                              turn_hold_enable,
    output gsdq_pkg::lane_result_t            result
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_SQUARE,
        L_SCALE,
        L_ROOT
    } lane_state_t;

    lane_state_t                      state_reg;
    logic [gsdq_pkg::StepW-1:0]       step_reg;
    logic                             done_reg;
    gsdq_pkg::dir_t                   dir_reg;
    logic [gsdq_pkg::PctW-1:0]        power_reg;
    logic                             went_down_reg;

    logic [gsdq_pkg::AxisW:0]         ax_reg;
    logic [gsdq_pkg::AxisW:0]         ay_reg;
    logic [gsdq_pkg::SqW-1:0]         sqx_reg;
    logic [gsdq_pkg::SqW-1:0]         sqy_reg;
    logic [gsdq_pkg::RadW-1:0]        rad_reg;
    logic [gsdq_pkg::RemW-1:0]        rem_reg;
    logic [gsdq_pkg::RootW-1:0]       root_reg;

    // Direction decode, strict margin compares
    logic signed [gsdq_pkg::AxisW:0]  xs, ys, mp, mn;
    logic                             x_hi, x_lo, y_hi, y_lo, xc, yc;
    gsdq_pkg::dir_t                   dir_next;
    logic                             went_down_next;

    always_comb
    begin
        xs   = $signed({x[gsdq_pkg::AxisW-1], x});
        ys   = $signed({y[gsdq_pkg::AxisW-1], y});
        mp   = $signed({2'b00, dead_zone});
        mn   = -mp;
        x_hi = xs > mp;
        x_lo = xs < mn;
        y_hi = ys > mp;
        y_lo = ys < mn;
        xc   = (xs > mn) && (xs < mp);
        yc   = (ys > mn) && (ys < mp);
        went_down_next = went_down_reg;
        priority if (x_hi && y_lo)
        begin
            dir_next = gsdq_pkg::DIR_NE;
            if (turn_hold_enable) went_down_next = 1'b0;
        end
        else if (x_hi && y_hi)
        begin
            dir_next = gsdq_pkg::DIR_SE;
            if (turn_hold_enable) went_down_next = 1'b1;
        end
        else if (x_lo && y_lo)
        begin
            dir_next = gsdq_pkg::DIR_NW;
            if (turn_hold_enable) went_down_next = 1'b0;
        end
        else if (x_lo && y_hi)
        begin
            dir_next = gsdq_pkg::DIR_SW;
            if (turn_hold_enable) went_down_next = 1'b1;
        end
        else if (xc && y_lo)
        begin
            dir_next = gsdq_pkg::DIR_N;
        end
        else if (xc && y_hi)
        begin
            dir_next = gsdq_pkg::DIR_S;
        end
        else if (yc && x_hi)
        begin
            dir_next = !turn_hold_enable ? gsdq_pkg::DIR_E :
                       (went_down_reg ? gsdq_pkg::DIR_SE : gsdq_pkg::DIR_NE);
        end
        else if (yc && x_lo)
        begin
            dir_next = !turn_hold_enable ? gsdq_pkg::DIR_W :
                       (went_down_reg ? gsdq_pkg::DIR_SW : gsdq_pkg::DIR_NW);
        end
        else
        begin
            dir_next = gsdq_pkg::DIR_NONE;
        end
    end

    // One restoring square root step: two radicand bits in, one root bit out
    logic [gsdq_pkg::RemW:0]          rem_shift;
    logic [gsdq_pkg::RemW:0]          trial;
    logic [gsdq_pkg::RemW:0]          diff;
    logic                             fits;
    logic [gsdq_pkg::RemW-1:0]        rem_next;
    logic [gsdq_pkg::RootW-1:0]       root_next;
    logic [gsdq_pkg::PowerW-1:0]      pct_raw;
    logic [gsdq_pkg::PctW-1:0]        pct_next;
    logic [gsdq_pkg::AxisW:0]         ax_next, ay_next;

    always_comb
    begin
        rem_shift = {rem_reg[gsdq_pkg::RemW-2:0], rad_reg[gsdq_pkg::RadW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_shift - trial;
        fits      = rem_shift >= trial;
        rem_next  = fits ? diff[gsdq_pkg::RemW-1:0] : rem_shift[gsdq_pkg::RemW-1:0];
        root_next = {root_reg[gsdq_pkg::RootW-2:0], fits};
        pct_raw   = root_next[gsdq_pkg::PowerShift +: gsdq_pkg::PowerW];
        pct_next  = (pct_raw > gsdq_pkg::PowerW'(gsdq_pkg::PowerMax)) ?
                    gsdq_pkg::PowerMax : pct_raw[gsdq_pkg::PctW-1:0];
        ax_next   = x[gsdq_pkg::AxisW-1] ? ((gsdq_pkg::AxisW+1)'(0) - xs) : xs;
        ay_next   = y[gsdq_pkg::AxisW-1] ? ((gsdq_pkg::AxisW+1)'(0) - ys) : ys;
    end

    // Lane sequencer and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= L_IDLE;
            step_reg      <= '0;
            done_reg      <= 1'b0;
            dir_reg       <= gsdq_pkg::DIR_NONE;
            power_reg     <= '0;
            went_down_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        dir_reg       <= dir_next;
                        went_down_reg <= went_down_next;
                        state_reg     <= L_SQUARE;
                    end
                end
                L_SQUARE:
                begin
                    state_reg <= L_SCALE;
                end
                L_SCALE:
                begin
                    step_reg  <= gsdq_pkg::StepW'(gsdq_pkg::RootSteps - 1);
                    state_reg <= L_ROOT;
                end
                L_ROOT:
                begin
                    if (step_reg == '0)
                    begin
                        power_reg <= pct_next;
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                    step_reg <= step_reg - 1'b1;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    // Magnitude datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && start)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (state_reg == L_SQUARE)
        begin
            sqx_reg <= gsdq_pkg::SqW'(ax_reg) * gsdq_pkg::SqW'(ax_reg);
            sqy_reg <= gsdq_pkg::SqW'(ay_reg) * gsdq_pkg::SqW'(ay_reg);
        end
        if (state_reg == L_SCALE)
        begin
            rad_reg  <= gsdq_pkg::RadW'(({1'b0, sqx_reg} + {1'b0, sqy_reg}) *
                                        gsdq_pkg::RadW'(10000));
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == L_ROOT)
        begin
            rad_reg  <= {rad_reg[gsdq_pkg::RadW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign result.done      = done_reg;
    assign result.direction = dir_reg;
    assign result.power     = power_reg;

    // Checks
    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != L_IDLE) |-> !start;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy)
        else $error("lane started while busy");

    property p_done_from_root;
        @(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == L_ROOT);
    endproperty
    a_done_from_root: assert property (p_done_from_root)
        else $error("lane done without root pass");

    property p_power_clamped;
        @(posedge clk) disable iff (!rst_n)
        done_reg |-> (power_reg <= gsdq_pkg::PowerMax);
    endproperty
    a_power_clamped: assert property (p_power_clamped)
        else $error("stick power above clamp");

endmodule

[src/gamepad_stick_direction_quantizer.sv]
// Top level: config registers, two stick lanes, trigger logic and output merge.
// One sample is in flight at a time: the next is accepted once the previous result has been
// loaded into the output register. Each stick lane finds the magnitude with the 23-step
// bit-pair square root.
// A result waiting in the output register does not block the next sample.
// Reset: async active low; dead zone 2000, turn hold off, power on,
// turn-hold flags clear, held power values -1.
`timescale 1ns / 1ps

module gamepad_stick_direction_quantizer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Sample stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // left_x, left_y, right_x, right_y, left_trigger, right_trigger (16 b each)
    input  logic [gsdq_pkg::InDataW-1:0]          s_tdata,
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // left_direction(4), right_direction(4), left_power(8), right_power(8),
    // left_trigger_held(1), right_trigger_held(1), left_trigger_power(8),
    // right_trigger_power(8), zero pad(6)
    output logic [gsdq_pkg::OutDataW-1:0]         m_tdata,
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gsdq_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [gsdq_pkg::MarginW-1:0]          cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } top_state_t;

    top_state_t                         state_reg;
    logic                               m_tvalid_reg;
    logic [gsdq_pkg::OutDataW-1:0]      m_tdata_reg;

    logic [gsdq_pkg::MarginW-1:0]       dead_zone_reg;
    logic                               turn_hold_reg;
    logic                               power_en_reg;

    logic [gsdq_pkg::PowerW-1:0]        stick_pow_reg [2];
    logic [gsdq_pkg::PowerW-1:0]        trig_pow_reg  [2];
    logic [gsdq_pkg::PctW-1:0]          trig_pct_reg  [2];
    logic                               trig_held_reg [2];

    gsdq_pkg::lane_result_t             left_res;
    gsdq_pkg::lane_result_t             right_res;

    logic                               in_fire;
    logic                               out_load;
    logic [gsdq_pkg::PowerW-1:0]        stick_pow_next [2];
    logic [gsdq_pkg::PowerW-1:0]        trig_pow_next  [2];
    logic [gsdq_pkg::OutDataW-1:0]      m_tdata_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Stick lanes
    gsdq_stick_lane u_left_lane (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (in_fire),
        .x                (s_tdata[15:0]),
        .y                (s_tdata[31:16]),
        .dead_zone        (dead_zone_reg),
        .turn_hold_enable (turn_hold_reg),
        .result           (left_res)
    );

    gsdq_stick_lane u_right_lane (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (in_fire),
        .x                (s_tdata[47:32]),
        .y                (s_tdata[63:48]),
        .dead_zone        (dead_zone_reg),
        .turn_hold_enable (turn_hold_reg),
        .result           (right_res)
    );

    // Merge: pick fresh or held power values and pack the result
    always_comb
    begin
        out_load = ((state_reg == ST_RUN && left_res.done) || state_reg == ST_HOLD) &&
                   (!m_tvalid_reg || m_tready);
        if (power_en_reg)
        begin
            stick_pow_next[0] = {1'b0, left_res.power};
            stick_pow_next[1] = {1'b0, right_res.power};
            trig_pow_next[0]  = {1'b0, trig_pct_reg[0]};
            trig_pow_next[1]  = {1'b0, trig_pct_reg[1]};
        end
        else
        begin
            stick_pow_next[0] = stick_pow_reg[0];
            stick_pow_next[1] = stick_pow_reg[1];
            trig_pow_next[0]  = trig_pow_reg[0];
            trig_pow_next[1]  = trig_pow_reg[1];
        end
        m_tdata_next = {6'b000000,
                        trig_pow_next[1], trig_pow_next[0],
                        trig_held_reg[1], trig_held_reg[0],
                        stick_pow_next[1], stick_pow_next[0],
                        right_res.direction, left_res.direction};
    end

    // Control state, output valid and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            dead_zone_reg    <= gsdq_pkg::DeadZoneReset;
            turn_hold_reg    <= 1'b0;
            power_en_reg     <= 1'b1;
            stick_pow_reg[0] <= gsdq_pkg::PowerUnknown;
            stick_pow_reg[1] <= gsdq_pkg::PowerUnknown;
            trig_pow_reg[0]  <= gsdq_pkg::PowerUnknown;
            trig_pow_reg[1]  <= gsdq_pkg::PowerUnknown;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire) state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (left_res.done) state_reg <= out_load ? ST_IDLE : ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_load) state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (out_load)
            begin
                m_tvalid_reg     <= 1'b1;
                stick_pow_reg[0] <= stick_pow_next[0];
                stick_pow_reg[1] <= stick_pow_next[1];
                trig_pow_reg[0]  <= trig_pow_next[0];
                trig_pow_reg[1]  <= trig_pow_next[1];
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    gsdq_pkg::CfgDeadZone: dead_zone_reg <= cfg_data;
                    gsdq_pkg::CfgTurnHold: turn_hold_reg <= cfg_data[0];
                    gsdq_pkg::CfgPowerEn:  power_en_reg  <= cfg_data[0];
                    default:               ;
                endcase
            end
        end
    end

    // Trigger results captured with the sample, output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            trig_pct_reg[0]  <= gsdq_pkg::trigger_power(s_tdata[79:64]);
            trig_pct_reg[1]  <= gsdq_pkg::trigger_power(s_tdata[95:80]);
            trig_held_reg[0] <= gsdq_pkg::trigger_held(s_tdata[79:64], dead_zone_reg);
            trig_held_reg[1] <= gsdq_pkg::trigger_held(s_tdata[95:80], dead_zone_reg);
        end
        if (out_load)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Checks
    property p_lanes_in_step;
        @(posedge clk) disable iff (!rst_n)
        left_res.done == right_res.done;
    endproperty
    a_lanes_in_step: assert property (p_lanes_in_step)
        else $error("stick lanes finished on different cycles");

    property p_done_only_running;
        @(posedge clk) disable iff (!rst_n)
        left_res.done |-> (state_reg == ST_RUN);
    endproperty
    a_done_only_running: assert property (p_done_only_running)
        else $error("lane result outside a running transaction");

    property p_load_sets_valid;
        @(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg;
    endproperty
    a_load_sets_valid: assert property (p_load_sets_valid)
        else $error("result load did not raise valid");

    property p_one_in_flight;
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("second sample taken while one is in flight");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the gamepad stick direction quantizer.
`timescale 1ns / 1ps

module tb_top;

    localparam int CycleLimit   = 800000;
    localparam int HoldOffLen   = 400;
    localparam int MaxPrinted   = 40;
    localparam int DrainCycles  = 40;
    localparam int PhaseItems   = 215;
    localparam logic [gsdq_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

    // One gamepad sample, axes as signed 16-bit values
    typedef struct {
        logic signed [gsdq_pkg::AxisW-1:0] lx;
        logic signed [gsdq_pkg::AxisW-1:0] ly;
        logic signed [gsdq_pkg::AxisW-1:0] rx;
        logic signed [gsdq_pkg::AxisW-1:0] ry;
        logic signed [gsdq_pkg::AxisW-1:0] lt;
        logic signed [gsdq_pkg::AxisW-1:0] rt;
    } pad_sample_t;

    // One quantized pad status as it leaves the block
    typedef struct {
        gsdq_pkg::dir_t              left_dir;
        gsdq_pkg::dir_t              right_dir;
        logic [gsdq_pkg::PowerW-1:0] left_pwr;
        logic [gsdq_pkg::PowerW-1:0] right_pwr;
        logic                        left_held;
        logic                        right_held;
        logic [gsdq_pkg::PowerW-1:0] left_tpwr;
        logic [gsdq_pkg::PowerW-1:0] right_tpwr;
    } pad_status_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gsdq_pkg::InDataW-1:0]   s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gsdq_pkg::OutDataW-1:0]  m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gsdq_pkg::CfgIdxW-1:0]   cfg_index = gsdq_pkg::CfgDeadZone;
    logic [gsdq_pkg::MarginW-1:0]   cfg_data = '0;

    // Predictor copy of config and state
    logic [gsdq_pkg::MarginW-1:0]   margin = gsdq_pkg::DeadZoneReset;
    logic                           turn_hold = 1'b0;
    logic                           power_on = 1'b1;
    logic                           left_down = 1'b0;
    logic                           right_down = 1'b0;
    logic [gsdq_pkg::PowerW-1:0]    held_stick [2] =
        '{gsdq_pkg::PowerUnknown, gsdq_pkg::PowerUnknown};
    logic [gsdq_pkg::PowerW-1:0]    held_trig [2] =
        '{gsdq_pkg::PowerUnknown, gsdq_pkg::PowerUnknown};

    pad_status_t status_due [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          stall_age = 0;
    int          stall_phase = 0;

    gamepad_stick_direction_quantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout at cycle %0d, %0d results outstanding", cycles, status_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Stick magnitude: floor(isqrt(10000*(x*x+y*y)) / 32768), clamped to 100
    function automatic logic [gsdq_pkg::PowerW-1:0] stick_magnitude(input int x, input int y);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned cand;
        ax   = (x < 0) ? longint'(-x) : longint'(x);
        ay   = (y < 0) ? longint'(-y) : longint'(y);
        rad  = 64'd10000 * (ax * ax + ay * ay);
        root = 0;
        // binary search for the floor root, one bit at a time from the top
        for (int b = 23; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand * cand <= rad)
                root = cand;
        end
        root = root >> 15;
        if (root > 100)
            root = 100;
        return gsdq_pkg::PowerW'(root);
    endfunction

    // Trigger percent, quotient truncated toward zero
    function automatic logic [gsdq_pkg::PowerW-1:0] trigger_percent(input int t);
        int mag;
        int q;
        mag = (t < 0) ? -t : t;
        q   = (25 * mag) / 16384;
        return gsdq_pkg::PowerW'(((t < 0) ? -q : q) + 50);
    endfunction

    // Eight-way direction with strict dead zone and optional turn hold
    function automatic gsdq_pkg::dir_t stick_direction(input int x, input int y, input int m,
                                                       inout logic down);
        logic xc;
        logic yc;
        xc = (x > -m) && (x < m);
        yc = (y > -m) && (y < m);
        if (x > m && y < -m)
        begin
            if (turn_hold) down = 1'b0;
            return gsdq_pkg::DIR_NE;
        end
        if (x > m && y > m)
        begin
            if (turn_hold) down = 1'b1;
            return gsdq_pkg::DIR_SE;
        end
        if (x < -m && y < -m)
        begin
            if (turn_hold) down = 1'b0;
            return gsdq_pkg::DIR_NW;
        end
        if (x < -m && y > m)
        begin
            if (turn_hold) down = 1'b1;
            return gsdq_pkg::DIR_SW;
        end
        if (xc && y < -m)
            return gsdq_pkg::DIR_N;
        if (xc && y > m)
            return gsdq_pkg::DIR_S;
        if (yc && x > m)
            return turn_hold ? (down ? gsdq_pkg::DIR_SE : gsdq_pkg::DIR_NE)
                             : gsdq_pkg::DIR_E;
        if (yc && x < -m)
            return turn_hold ? (down ? gsdq_pkg::DIR_SW : gsdq_pkg::DIR_NW)
                             : gsdq_pkg::DIR_W;
        return gsdq_pkg::DIR_NONE;
    endfunction

    // Expected status for one accepted sample; advances predictor state
    function automatic pad_status_t quantize_pad(input pad_sample_t smp);
        pad_status_t r;
        int          m;
        int          thr;
        m   = int'(margin);
        thr = 2 * m - 32768;
        if (power_on)
        begin
            held_stick[0] = stick_magnitude(smp.lx, smp.ly);
            held_stick[1] = stick_magnitude(smp.rx, smp.ry);
            held_trig[0]  = trigger_percent(smp.lt);
            held_trig[1]  = trigger_percent(smp.rt);
        end
        r.left_dir   = stick_direction(smp.lx, smp.ly, m, left_down);
        r.right_dir  = stick_direction(smp.rx, smp.ry, m, right_down);
        r.left_pwr   = held_stick[0];
        r.right_pwr  = held_stick[1];
        r.left_held  = int'(smp.lt) > thr;
        r.right_held = int'(smp.rt) > thr;
        r.left_tpwr  = held_trig[0];
        r.right_tpwr = held_trig[1];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic pad_sample_t make_sample(input int lx, input int ly, input int rx,
                                                input int ry, input int lt, input int rt);
        pad_sample_t s;
        s.lx = gsdq_pkg::AxisW'(lx);
        s.ly = gsdq_pkg::AxisW'(ly);
        s.rx = gsdq_pkg::AxisW'(rx);
        s.ry = gsdq_pkg::AxisW'(ry);
        s.lt = gsdq_pkg::AxisW'(lt);
        s.rt = gsdq_pkg::AxisW'(rt);
        return s;
    endfunction

    function automatic int clamp_axis(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Axis value biased toward the dead-zone edges
    function automatic int rand_axis(input int m);
        int v;
        case ($urandom_range(0, 9))
            0: v = int'($signed(16'($urandom)));
            1: v = -32768;
            2: v = 32767;
            3: v = m;
            4: v = -m;
            5: v = m + 1;
            6: v = -m - 1;
            7: v = (m == 0) ? 0 : int'($urandom_range(0, 2 * m - 2)) - (m - 1);
            8: v = (m < 32767) ? int'($urandom_range(m + 1, 32767)) : 32767;
            default: v = -int'($urandom_range(m + 1, 32768));
        endcase
        return clamp_axis(v);
    endfunction

    // Trigger value biased toward the hold threshold
    function automatic int rand_trigger(input int m);
        int thr;
        int v;
        thr = 2 * m - 32768;
        case ($urandom_range(0, 6))
            0, 1: v = int'($signed(16'($urandom)));
            2: v = thr;
            3: v = thr + 1;
            4: v = thr - 1;
            5: v = -32768;
            default: v = 32767;
        endcase
        return clamp_axis(v);
    endfunction

    function automatic pad_sample_t random_sample();
        int m;
        m = int'(margin);
        return make_sample(rand_axis(m), rand_axis(m), rand_axis(m), rand_axis(m),
                           rand_trigger(m), rand_trigger(m));
    endfunction

    // Offer one sample; bursts of random length with random gaps between them
    task automatic send_sample(input pad_sample_t smp);
        int gap;
        if (burst_left == 0)
        begin
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {smp.rt, smp.lt, smp.ry, smp.rx, smp.ly, smp.lx};
        do @(posedge clk); while (s_tready !== 1'b1);
        status_due.push_back(quantize_pad(smp));
        burst_left--;
    endtask

    // Stop offering and wait for every outstanding status
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (status_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Register write transaction, only with the block idle
    task automatic write_reg(input logic [gsdq_pkg::CfgIdxW-1:0] idx,
                             input logic [gsdq_pkg::MarginW-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            gsdq_pkg::CfgDeadZone: margin    = value;
            gsdq_pkg::CfgTurnHold: turn_hold = value[0];
            gsdq_pkg::CfgPowerEn:  power_on  = value[0];
            default: ;
        endcase
    endtask

    function automatic logic [gsdq_pkg::MarginW-1:0] flag_word(input logic on);
        return {14'($urandom), on};
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what,
                                   input logic [gsdq_pkg::OutDataW-1:0] got,
                                   input logic [gsdq_pkg::OutDataW-1:0] want);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("cycle %0d: %s mismatch, got %h expected %h", cycles, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [gsdq_pkg::PowerW-1:0] got,
                                 input logic [gsdq_pkg::PowerW-1:0] want);
        if (got !== want)
            report_mismatch(what, gsdq_pkg::OutDataW'(got), gsdq_pkg::OutDataW'(want));
    endtask

    task automatic check_status(input logic [gsdq_pkg::OutDataW-1:0] data);
        pad_status_t want;
        if (status_due.size() == 0)
        begin
            report_mismatch("unexpected transaction", data, '0);
            return;
        end
        want = status_due.pop_front();
        compare_field("left_direction", gsdq_pkg::PowerW'(data[3:0]),
                      gsdq_pkg::PowerW'(want.left_dir));
        compare_field("right_direction", gsdq_pkg::PowerW'(data[7:4]),
                      gsdq_pkg::PowerW'(want.right_dir));
        compare_field("left_power", data[15:8], want.left_pwr);
        compare_field("right_power", data[23:16], want.right_pwr);
        compare_field("left_trigger_held", gsdq_pkg::PowerW'(data[24]),
                      gsdq_pkg::PowerW'(want.left_held));
        compare_field("right_trigger_held", gsdq_pkg::PowerW'(data[25]),
                      gsdq_pkg::PowerW'(want.right_held));
        compare_field("left_trigger_power", data[33:26], want.left_tpwr);
        compare_field("right_trigger_power", data[41:34], want.right_tpwr);
    endtask

    // Long receiver hold-off, requested by bumping hold_seq
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HoldOffLen;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: check accepted transactions, then pick next ready value
    always @(posedge clk)
    begin : receiver
        logic ready_next;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            check_status(m_tdata);
        if (stall_age == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_age   = $urandom_range(16, 96);
        end
        else
            stall_age = stall_age - 1;
        stall_phase = stall_phase + 1;
        case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = $urandom_range(0, 1);
            2: ready_next = (stall_phase % 5) == 0;
            default: ready_next = $urandom_range(0, 3) != 0;
        endcase
        m_tready <= (hold_left == 0) && ready_next;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset margin and turn hold, power off so the unknown power shows
    task automatic test_power_unknown();
        write_reg(gsdq_pkg::CfgPowerEn, flag_word(1'b0));
        send_sample(make_sample(0, 0, 0, 0, -32768, -32768));
        send_sample(make_sample(2000, 0, 2001, 0, 32767, -28768));
        send_sample(make_sample(0, -2001, -2001, 0, -28767, 0));
    endtask

    // Axis and trigger extremes, values on and just past the margin
    task automatic test_extremes();
        write_reg(gsdq_pkg::CfgPowerEn, flag_word(1'b1));
        write_reg(gsdq_pkg::CfgDeadZone, gsdq_pkg::DeadZoneReset);
        send_sample(make_sample(-32768, -32768, 32767, 32767, -32768, 32767));
        send_sample(make_sample(32767, -32768, -32768, 32767, 0, 1));
        send_sample(make_sample(0, 32767, -32768, 0, 16384, -16384));
        send_sample(make_sample(2000, -2000, -2000, 2000, -1, 16383));
        send_sample(make_sample(2001, 1999, -1999, -2001, 655, -656));
        send_sample(make_sample(2000, -2001, -2001, 2000, -28769, -28768));
    endtask

    // Turn hold: pure east or west follows the last diagonal's vertical sense
    task automatic test_turn_hold();
        write_reg(gsdq_pkg::CfgTurnHold, flag_word(1'b1));
        send_sample(make_sample(2001, 2001, -2001, -2001, 0, 0));
        send_sample(make_sample(3000, 0, 3000, 0, 0, 0));
        send_sample(make_sample(-3000, 5, -3000, -5, 0, 0));
        send_sample(make_sample(-2001, -2001, 2001, 2001, 0, 0));
        send_sample(make_sample(-32768, 0, 32767, 0, 0, 0));
        write_reg(gsdq_pkg::CfgTurnHold, flag_word(1'b0));
        send_sample(make_sample(2001, 2001, 2001, 0, 0, 0));
    endtask

    // Zero margin: only diagonals or no direction come out
    task automatic test_zero_margin();
        write_reg(gsdq_pkg::CfgDeadZone, '0);
        send_sample(make_sample(0, 0, 0, 0, -32768, -32767));
        send_sample(make_sample(5, 0, 0, -5, -32767, -32768));
        send_sample(make_sample(1, 1, -1, -1, 0, 0));
    endtask

    // Full margin: only -32768 passes the stick margin, trigger threshold at 32766
    task automatic test_full_margin();
        write_reg(gsdq_pkg::CfgDeadZone, 15'h7FFF);
        send_sample(make_sample(32767, 32767, -32768, -32768, 32767, 32766));
    endtask

    // Power off after computed values: last values are repeated
    task automatic test_power_hold();
        write_reg(gsdq_pkg::CfgPowerEn, flag_word(1'b0));
        write_reg(gsdq_pkg::CfgDeadZone, 15'd100);
        send_sample(make_sample(0, 0, 101, 0, 0, 32767));
        write_reg(gsdq_pkg::CfgPowerEn, flag_word(1'b1));
    endtask

    // Write to an index with no register behind it changes nothing
    task automatic test_unused_index();
        write_reg(CfgUnused, 15'($urandom));
        send_sample(make_sample(-101, 101, 0, 0, -200, 32767));
    endtask

    // Random samples over several register settings
    task automatic test_random_phases();
        int dz_list [6] = '{2000, 0, 32767, 1, -1, 16000};
        bit th_list [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        bit pw_list [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(gsdq_pkg::CfgDeadZone,
                      (dz_list[p] < 0) ? gsdq_pkg::MarginW'($urandom_range(2, 32766))
                                       : gsdq_pkg::MarginW'(dz_list[p]));
            write_reg(gsdq_pkg::CfgTurnHold, flag_word(th_list[p]));
            write_reg(gsdq_pkg::CfgPowerEn, flag_word(pw_list[p]));
            repeat (PhaseItems) send_sample(random_sample());
        end
    endtask

    // Receiver holds off for a long stretch while samples keep coming
    task automatic test_backpressure();
        write_reg(gsdq_pkg::CfgDeadZone, gsdq_pkg::MarginW'($urandom_range(500, 8000)));
        write_reg(gsdq_pkg::CfgTurnHold, flag_word(1'b1));
        write_reg(gsdq_pkg::CfgPowerEn, flag_word(1'b1));
        no_gaps = 1'b1;
        hold_seq++;
        repeat (60) send_sample(random_sample());
        no_gaps = 1'b0;
        drain();
    endtask

    // Sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_unknown();
        test_extremes();
        test_turn_hold();
        test_zero_margin();
        test_full_margin();
        test_power_hold();
        test_unused_index();
        test_random_phases();
        test_backpressure();
        drain();
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[gamepad_stick_direction_quantizer.f]
src/gsdq_pkg.sv
src/gsdq_stick_lane.sv
src/gamepad_stick_direction_quantizer.sv
tb/tb_top.sv
